// File: rtl/repf_pkg.sv
// Shared types, constants and lookup functions of the radial edge point finder.
package repf_pkg;

    localparam int GRAY_W = 16;
    localparam int COL_W = 12;
    localparam int GRAD_W = 19;
    localparam int CVEC_W = 15;
    localparam int DIM_W = 13;
    localparam int SCORE_W = 16;
    localparam int U_W = 13;
    localparam int SQ_IN_W = 54;
    localparam int SQ_ROOT_W = 27;
    localparam int SQ_CNT_W = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int IN_DATA_W = 96;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MIN_CONFIDENCE = 2'd2;
    localparam logic [1:0] CFG_BORDER_DISCARD = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [SCORE_W-1:0] min_confidence;
        logic [7:0]         border_discard;
    } cfg_t;

    typedef struct packed {
        logic                     scan_start;
        logic                     scan_end;
        logic                     scan_side;
        logic                     scored;
        logic [COL_W-1:0]         row_y;
        logic [COL_W-1:0]         col_x;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [CVEC_W-1:0] ctr_x;
        logic signed [CVEC_W-1:0] ctr_y;
        logic [GRAY_W-1:0]        mid_gray;
    } job_t;

    function automatic logic [GRAY_W-1:0] gray_of(input logic [23:0] rgb);
        logic [24:0] sum;
        sum = 25'(rgb[7:0]) * 25'd13933 + 25'(rgb[15:8]) * 25'd46871
            + 25'(rgb[23:16]) * 25'd4732 + 25'd128;
        return sum[23:8];
    endfunction

    function automatic logic [15:0] tanh_entry(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0: v = 16'd0;
            5'd1: v = 16'd16051;
            5'd2: v = 16'd30285;
            5'd3: v = 16'd41625;
            5'd4: v = 16'd49912;
            5'd5: v = 16'd55593;
            5'd6: v = 16'd59320;
            5'd7: v = 16'd61694;
            5'd8: v = 16'd63179;
            5'd9: v = 16'd64096;
            5'd10: v = 16'd64659;
            5'd11: v = 16'd65002;
            5'd12: v = 16'd65212;
            5'd13: v = 16'd65339;
            5'd14: v = 16'd65417;
            5'd15: v = 16'd65463;
            default: v = 16'd65492;
        endcase
        return v;
    endfunction

    function automatic logic [13:0] asin_entry(input logic [4:0] i);
        logic [13:0] v;
        case (i)
            5'd0: v = 14'd0;
            5'd1: v = 14'd358;
            5'd2: v = 14'd718;
            5'd3: v = 14'd1081;
            5'd4: v = 14'd1448;
            5'd5: v = 14'd1821;
            5'd6: v = 14'd2202;
            5'd7: v = 14'd2594;
            5'd8: v = 14'd3000;
            5'd9: v = 14'd3423;
            5'd10: v = 14'd3868;
            5'd11: v = 14'd4343;
            5'd12: v = 14'd4859;
            5'd13: v = 14'd5434;
            5'd14: v = 14'd6104;
            5'd15: v = 14'd6964;
            default: v = 14'd9000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] tanh_q16(input logic [U_W-1:0] u);
        logic [4:0]  i;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [21:0] prod;
        logic [15:0] res;
        i = {1'b0, u[11:8]};
        lo = tanh_entry(i);
        hi = tanh_entry(i + 5'd1);
        prod = 22'(hi - lo) * 22'(u[7:0]) + 22'd128;
        if (u[12]) begin
            res = tanh_entry(5'd16);
        end else begin
            res = lo + 16'(prod >> 8);
        end
        return res;
    endfunction

    function automatic logic [15:0] one_minus(input logic [15:0] t);
        logic [15:0] res;
        if (t == 16'd0) begin
            res = 16'hFFFF;
        end else begin
            res = 16'd0 - t;
        end
        return res;
    endfunction

endpackage

// File: rtl/repf_front.sv
// Front part: accepts pixel columns, converts them to gray and forms the scoring job.
module repf_front import repf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,  // col_x, row_y, top_rgb, mid_rgb, bot_rgb
    input  logic [1:0]           s_tuser,  // scan_side, scan_start
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 push,
    output job_t                 push_job
);

    logic [GRAY_W-1:0] g0_reg [3];
    logic [GRAY_W-1:0] g1_reg [3];
    logic [1:0]        seen_reg;
    logic [COL_W-1:0]  centre_reg;

    logic [GRAY_W-1:0] cur [3];
    logic [GRAY_W-1:0] lft [3];
    logic [GRAY_W-1:0] rgt [3];
    logic [1:0]        seen_eff;
    logic [GRAD_W-1:0] sum_l;
    logic [GRAD_W-1:0] sum_r;
    logic [GRAD_W-1:0] sum_t;
    logic [GRAD_W-1:0] sum_b;
    logic              side;
    logic              start;

    assign side = s_tuser[0];
    assign start = s_tuser[1];
    assign s_tready = !q_full;
    assign push = s_tvalid && !q_full;

    always_comb begin
        cur[0] = gray_of(s_tdata[47:24]);
        cur[1] = gray_of(s_tdata[71:48]);
        cur[2] = gray_of(s_tdata[95:72]);
        for (int k = 0; k < 3; k++) begin
            lft[k] = side ? cur[k] : g1_reg[k];
            rgt[k] = side ? g1_reg[k] : cur[k];
        end
        seen_eff = start ? 2'd0 : seen_reg;
        sum_l = {3'b0, lft[0]} + {2'b0, lft[1], 1'b0} + {3'b0, lft[2]};
        sum_r = {3'b0, rgt[0]} + {2'b0, rgt[1], 1'b0} + {3'b0, rgt[2]};
        sum_t = {3'b0, lft[0]} + {2'b0, g0_reg[0], 1'b0} + {3'b0, rgt[0]};
        sum_b = {3'b0, lft[2]} + {2'b0, g0_reg[2], 1'b0} + {3'b0, rgt[2]};

        push_job.scan_start = start;
        push_job.scan_end = s_tlast;
        push_job.scan_side = side;
        push_job.scored = seen_eff == 2'd2;
        push_job.row_y = s_tdata[23:12];
        push_job.col_x = centre_reg;
        push_job.grad_x = $signed(sum_r - sum_l);
        push_job.grad_y = $signed(sum_b - sum_t);
        push_job.ctr_x = $signed({2'b0, cfg.frame_width} - {2'b0, centre_reg, 1'b0});
        push_job.ctr_y = $signed({2'b0, cfg.frame_height} - {2'b0, s_tdata[23:12], 1'b0});
        push_job.mid_gray = g0_reg[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 2'd0;
            centre_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                g0_reg[k] <= '0;
                g1_reg[k] <= '0;
            end
        end else if (push) begin
            for (int k = 0; k < 3; k++) begin
                g1_reg[k] <= g0_reg[k];
                g0_reg[k] <= cur[k];
            end
            centre_reg <= s_tdata[11:0];
            seen_reg <= (seen_eff == 2'd2) ? 2'd2 : seen_eff + 2'd1;
        end
    end

endmodule

// File: rtl/repf_queue.sv
// Short job queue between the front part and the scoring back part.
module repf_queue import repf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W:0]   count_reg;

    assign full = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/repf_isqrt.sv
// Iterative integer square root, two operand bits per cycle.
module repf_isqrt import repf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SQ_IN_W-1:0]   operand,
    output logic                 done,
    output logic [SQ_ROOT_W-1:0] root
);

    logic                busy_reg;
    logic                done_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SQ_IN_W-1:0]  v_reg;
    logic [SQ_IN_W-1:0]  r_reg;

    logic [SQ_IN_W-1:0]  step_val;
    logic [SQ_IN_W:0]    trial;

    assign step_val = {{(SQ_IN_W-1){1'b0}}, 1'b1} << {cnt_reg, 1'b0};
    assign trial = {1'b0, r_reg} + {1'b0, step_val};
    assign done = done_reg;
    assign root = r_reg[SQ_ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= SQ_CNT_W'(SQ_ROOT_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg <= operand;
            r_reg <= '0;
        end else if (busy_reg) begin
            if ({1'b0, v_reg} >= trial) begin
                v_reg <= v_reg - trial[SQ_IN_W-1:0];
                r_reg <= (r_reg >> 1) + step_val;
            end else begin
                r_reg <= r_reg >> 1;
            end
        end
    end

endmodule

// File: rtl/repf_back.sv
// Back part: scores queued columns with shared iterative units and tracks the best point.
module repf_back import repf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  q_empty,
    input  job_t                  q_head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // point_x, row_out, score
    output logic [1:0]            m_tuser   // side_out, point_valid
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL = 4'd1;
    localparam logic [3:0] ST_SQG = 4'd2;
    localparam logic [3:0] ST_SQC = 4'd3;
    localparam logic [3:0] ST_DEN = 4'd4;
    localparam logic [3:0] ST_DIV = 4'd5;
    localparam logic [3:0] ST_ASIN = 4'd6;
    localparam logic [3:0] ST_UE = 4'd7;
    localparam logic [3:0] ST_TE = 4'd8;
    localparam logic [3:0] ST_UA = 4'd9;
    localparam logic [3:0] ST_TA = 4'd10;
    localparam logic [3:0] ST_UG = 4'd11;
    localparam logic [3:0] ST_TG = 4'd12;
    localparam logic [3:0] ST_P1 = 4'd13;
    localparam logic [3:0] ST_P2 = 4'd14;
    localparam logic [3:0] ST_DONE = 4'd15;

    logic [3:0]               state_reg;
    job_t                     job_reg;
    logic [GRAY_W-1:0]        rmax_reg;
    logic [SCORE_W-1:0]       best_reg;
    logic [COL_W-1:0]         bcol_reg;
    logic [4:0]               step_reg;
    logic [37:0]              g2_reg;
    logic [26:0]              c2_reg;
    logic signed [34:0]       dot_reg;
    logic [SQ_ROOT_W-1:0]     ng_reg;
    logic [21:0]              nc_reg;
    logic [48:0]              den_reg;
    logic [63:0]              rem_reg;
    logic [16:0]              quo_reg;
    logic                     neg_reg;
    logic [14:0]              angle_reg;
    logic [U_W-1:0]           u_reg;
    logic [15:0]              e_reg;
    logic [15:0]              as_reg;
    logic [15:0]              is_reg;
    logic [15:0]              p1_reg;
    logic                     mvalid_reg;
    logic [OUT_DATA_W-1:0]    mdata_reg;
    logic [1:0]               muser_reg;

    logic signed [GRAD_W-1:0] mul_a;
    logic signed [GRAD_W-1:0] mul_b;
    logic signed [37:0]       mul_prod;
    logic                     sq_start;
    logic [SQ_IN_W-1:0]       sq_operand;
    logic                     sq_done;
    logic [SQ_ROOT_W-1:0]     sq_root;
    logic [34:0]              dot_mag;
    logic [65:0]              div_trial;
    logic [14:0]              cq;
    logic [4:0]               as_idx;
    logic [13:0]              as_lo;
    logic [13:0]              as_hi;
    logic [21:0]              as_interp;
    logic [13:0]              asn;
    logic [14:0]              angle_calc;
    logic [27:0]              ne;
    logic [30:0]              pe;
    logic [U_W-1:0]           u_edge;
    logic [24:0]              na;
    logic [45:0]              pa;
    logic [U_W-1:0]           u_ang;
    logic [17:0]              ngy;
    logic [37:0]              pg;
    logic [U_W-1:0]           u_gray;
    logic [31:0]              p1_prod;
    logic [31:0]              p2_prod;
    logic [GRAY_W-1:0]        rbase;
    logic [GRAY_W-1:0]        rmax_new;
    logic                     pt_valid;
    logic                     out_load;

    assign pop = (state_reg == ST_IDLE) && !q_empty;
    assign m_tvalid = mvalid_reg;
    assign m_tdata = mdata_reg;
    assign m_tuser = muser_reg;

    repf_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .operand (sq_operand),
        .done    (sq_done),
        .root    (sq_root)
    );

    always_comb begin
        case (step_reg[2:0])
            3'd0: begin
                mul_a = job_reg.grad_x;
                mul_b = job_reg.grad_x;
            end
            3'd1: begin
                mul_a = job_reg.grad_y;
                mul_b = job_reg.grad_y;
            end
            3'd2: begin
                mul_a = GRAD_W'(job_reg.ctr_x);
                mul_b = GRAD_W'(job_reg.ctr_x);
            end
            3'd3: begin
                mul_a = GRAD_W'(job_reg.ctr_y);
                mul_b = GRAD_W'(job_reg.ctr_y);
            end
            3'd4: begin
                mul_a = GRAD_W'(job_reg.ctr_x);
                mul_b = job_reg.grad_x;
            end
            default: begin
                mul_a = GRAD_W'(job_reg.ctr_y);
                mul_b = job_reg.grad_y;
            end
        endcase
        mul_prod = mul_a * mul_b;

        sq_start = ((state_reg == ST_MUL) && (step_reg == 5'd5))
                || ((state_reg == ST_SQG) && sq_done && (g2_reg != '0));
        sq_operand = (state_reg == ST_MUL) ? {g2_reg, 16'b0} : {11'b0, c2_reg, 16'b0};

        dot_mag = dot_reg[34] ? 35'(-dot_reg) : 35'(dot_reg);
        div_trial = {17'b0, den_reg} << step_reg;

        cq = (quo_reg > 17'd16384) ? 15'd16384 : quo_reg[14:0];
        as_idx = cq[14:10];
        as_lo = asin_entry(as_idx);
        as_hi = asin_entry(as_idx + 5'd1);
        as_interp = 22'(as_hi - as_lo) * 22'(cq[9:0]) + 22'd512;
        asn = as_idx[4] ? 14'd9000 : as_lo + 14'(as_interp >> 10);
        angle_calc = neg_reg ? 15'd9000 + 15'(asn) : 15'd9000 - 15'(asn);

        ne = {1'b0, ng_reg} + 28'd2560;
        pe = 31'(ne[24:10]) * 31'd52429;
        u_edge = (ne >= 28'd20971520) ? U_W'(4096) : pe[30:18];

        na = {angle_reg, 10'b0} + 25'd1500;
        pa = 46'(na[24:3]) * 46'd11453247;
        u_ang = (na >= 25'd12288000) ? U_W'(4096) : pa[44:32];

        ngy = {rmax_reg, 2'b0} + 18'd12;
        pg = 38'(ngy) * 38'd671089;
        u_gray = (ngy >= 18'd102400) ? U_W'(4096) : pg[36:24];

        p1_prod = 32'(e_reg) * 32'(as_reg);
        p2_prod = 32'(p1_reg) * 32'(is_reg);

        rbase = q_head.scan_start ? '0 : rmax_reg;
        rmax_new = (q_head.scored && (q_head.mid_gray > rbase)) ? q_head.mid_gray : rbase;

        pt_valid = best_reg >= cfg.min_confidence;
        if (!job_reg.scan_side) begin
            if (bcol_reg <= {4'b0, cfg.border_discard}) begin
                pt_valid = 1'b0;
            end
        end else begin
            if ({2'b0, bcol_reg} + 14'd1 + {6'b0, cfg.border_discard}
                    >= {1'b0, cfg.frame_width}) begin
                pt_valid = 1'b0;
            end
        end

        out_load = (state_reg == ST_DONE) && job_reg.scan_end && (!mvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rmax_reg <= '0;
            best_reg <= '0;
            bcol_reg <= '0;
            mvalid_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (out_load) begin
                mvalid_reg <= 1'b1;
            end else if (mvalid_reg && m_tready) begin
                mvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        job_reg <= q_head;
                        if (q_head.scan_start) begin
                            best_reg <= '0;
                            bcol_reg <= '0;
                        end
                        rmax_reg <= rmax_new;
                        step_reg <= '0;
                        state_reg <= q_head.scored ? ST_MUL : ST_DONE;
                    end
                end
                ST_MUL: begin
                    case (step_reg[2:0])
                        3'd0: g2_reg <= $unsigned(mul_prod);
                        3'd1: g2_reg <= g2_reg + $unsigned(mul_prod);
                        3'd2: c2_reg <= mul_prod[26:0];
                        3'd3: c2_reg <= c2_reg + mul_prod[26:0];
                        3'd4: dot_reg <= mul_prod[34:0];
                        default: dot_reg <= dot_reg + mul_prod[34:0];
                    endcase
                    if (step_reg == 5'd5) begin
                        state_reg <= ST_SQG;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_SQG: begin
                    if (sq_done) begin
                        ng_reg <= sq_root;
                        if (g2_reg == '0) begin
                            angle_reg <= 15'd18000;
                            state_reg <= ST_UE;
                        end else begin
                            state_reg <= ST_SQC;
                        end
                    end
                end
                ST_SQC: begin
                    if (sq_done) begin
                        nc_reg <= sq_root[21:0];
                        state_reg <= (c2_reg == '0) ? ST_DONE : ST_DEN;
                    end
                end
                ST_DEN: begin
                    den_reg <= 49'(nc_reg) * 49'(ng_reg);
                    rem_reg <= {dot_mag[33:0], 30'b0};
                    neg_reg <= dot_reg[34];
                    quo_reg <= '0;
                    step_reg <= 5'd16;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if ({2'b0, rem_reg} >= div_trial) begin
                        rem_reg <= rem_reg - div_trial[63:0];
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end else begin
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    if (step_reg == '0) begin
                        state_reg <= ST_ASIN;
                    end else begin
                        step_reg <= step_reg - 5'd1;
                    end
                end
                ST_ASIN: begin
                    angle_reg <= angle_calc;
                    state_reg <= ST_UE;
                end
                ST_UE: begin
                    u_reg <= u_edge;
                    state_reg <= ST_TE;
                end
                ST_TE: begin
                    e_reg <= tanh_q16(u_reg);
                    state_reg <= ST_UA;
                end
                ST_UA: begin
                    u_reg <= u_ang;
                    state_reg <= ST_TA;
                end
                ST_TA: begin
                    as_reg <= one_minus(tanh_q16(u_reg));
                    state_reg <= ST_UG;
                end
                ST_UG: begin
                    u_reg <= u_gray;
                    state_reg <= ST_TG;
                end
                ST_TG: begin
                    is_reg <= one_minus(tanh_q16(u_reg));
                    state_reg <= ST_P1;
                end
                ST_P1: begin
                    p1_reg <= p1_prod[31:16];
                    state_reg <= ST_P2;
                end
                ST_P2: begin
                    if (p2_prod[31:16] > best_reg) begin
                        best_reg <= p2_prod[31:16];
                        bcol_reg <= job_reg.col_x;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!job_reg.scan_end) begin
                        state_reg <= ST_IDLE;
                    end else if (out_load) begin
                        muser_reg <= {pt_valid, job_reg.scan_side};
                        mdata_reg <= {pt_valid ? best_reg : 16'd0, job_reg.row_y,
                                      pt_valid ? bcol_reg : 12'd0};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/radial_edge_point_finder_core.sv
// Top level of the radial edge point finder: configuration registers, front, queue and back.
// The back finishes columns one after another; a scored column uses two square roots and a
// 17-step divider, the second root and the divider skipped with zero gradient, and scoring
// ends after the second root at the image centre. The input takes a transfer each cycle
// until the 4-entry queue is full. Reset (aresetn low at a clock edge) clears all scan state.
module radial_edge_point_finder_core import repf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // col_x, row_y, top_rgb, mid_rgb, bot_rgb
    input  logic [1:0]            s_tuser,  // scan_side, scan_start
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // point_x, row_out, score
    output logic [1:0]            m_tuser   // side_out, point_valid
);

    cfg_t cfg_reg;
    logic q_push;
    job_t q_push_job;
    logic q_pop;
    job_t q_head;
    logic q_full;
    logic q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width <= 13'd640;
            cfg_reg.frame_height <= 13'd480;
            cfg_reg.min_confidence <= 16'd1966;
            cfg_reg.border_discard <= 8'd3;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: cfg_reg.frame_width <= cfg_data[12:0];
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[12:0];
                CFG_MIN_CONFIDENCE: cfg_reg.min_confidence <= cfg_data;
                CFG_BORDER_DISCARD: cfg_reg.border_discard <= cfg_data[7:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    repf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (q_push),
        .push_job (q_push_job)
    );

    repf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    repf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_full && q_empty))
        else $error("queue reports full and empty at once");

    a_invalid_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> (m_tdata[11:0] == 12'd0) && (m_tdata[39:24] == 16'd0))
        else $error("invalid point carries a column or score");

    a_left_not_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] && !m_tuser[0] |-> m_tdata[11:0] != 12'd0)
        else $error("valid left point at the image edge");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_empty && !q_push |=> !q_full)
        else $error("queue filled without a transfer");

endmodule

// File: bench/edge_point_checker.sv
// Checker of the radial edge point finder: predicts every result and compares the outputs.
`timescale 1ns / 100ps
module edge_point_checker import repf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]            m_tuser,
    output int                    fail_count,
    output int                    awaited
);

    typedef struct {
        bit        side;
        bit        found;
        bit [11:0] px;
        bit [11:0] row;
        bit [15:0] score;
    } edge_point_t;

    localparam int unsigned TANH_LUT[17] = '{0, 16051, 30285, 41625, 49912, 55593, 59320,
        61694, 63179, 64096, 64659, 65002, 65212, 65339, 65417, 65463, 65492};
    localparam int unsigned ASIN_LUT[17] = '{0, 358, 718, 1081, 1448, 1821, 2202, 2594,
        3000, 3423, 3868, 4343, 4859, 5434, 6104, 6964, 9000};

    edge_point_t points_due[$];
    bit [12:0]   frm_w;
    bit [12:0]   frm_h;
    bit [15:0]   min_conf;
    bit [7:0]    border;
    bit [15:0]   gray_new[3];
    bit [15:0]   gray_old[3];
    int          cols_held;
    bit [11:0]   ctr_col;
    bit [15:0]   max_gray;
    bit [15:0]   top_score;
    bit [11:0]   best_col;
    int          errs = 0;

    function automatic longint unsigned root_of(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int unsigned tanh_fix(input longint unsigned u);
        int unsigned i;
        int unsigned f;
        if (u >= 4096) return TANH_LUT[16];
        i = int'(u >> 8);
        f = int'(u & 255);
        return TANH_LUT[i] + (((TANH_LUT[i+1] - TANH_LUT[i]) * f + 128) >> 8);
    endfunction

    function automatic int unsigned inv_tanh(input int unsigned t);
        return (t == 0) ? 65535 : 65536 - t;
    endfunction

    function automatic bit [15:0] luma(input bit [23:0] rgb);
        int unsigned acc;
        acc = 13933 * rgb[7:0] + 46871 * rgb[15:8] + 4732 * rgb[23:16] + 128;
        return 16'(acc >> 8);
    endfunction

    function automatic int unsigned col_score(input bit [15:0] a[3], input bit [15:0] mm[3],
                                              input bit [15:0] b[3], input bit [11:0] mx,
                                              input bit [11:0] y);
        longint gx;
        longint gy;
        longint cx;
        longint cy;
        longint dot;
        longint unsigned g2;
        longint unsigned c2;
        longint unsigned ng;
        longint unsigned nc;
        longint unsigned mag;
        longint unsigned cq;
        int unsigned angle;
        int unsigned asn;
        int unsigned idx;
        int unsigned f;
        longint unsigned e;
        longint unsigned sa;
        longint unsigned sg;
        gx = (longint'(b[0]) + 2 * longint'(b[1]) + b[2]) - (longint'(a[0]) + 2 * longint'(a[1]) + a[2]);
        gy = (longint'(a[2]) + 2 * longint'(mm[2]) + b[2]) - (longint'(a[0]) + 2 * longint'(mm[0]) + b[0]);
        cx = longint'(frm_w) - 2 * longint'(mx);
        cy = longint'(frm_h) - 2 * longint'(y);
        g2 = gx * gx + gy * gy;
        c2 = cx * cx + cy * cy;
        ng = root_of(g2 << 16);
        if (g2 == 0) begin
            angle = 18000;
        end else begin
            if (c2 == 0) return 0;
            nc = root_of(c2 << 16);
            dot = cx * gx + cy * gy;
            mag = (dot < 0) ? -dot : dot;
            cq = (mag << 30) / (nc * ng);
            if (cq > 16384) cq = 16384;
            idx = int'(cq >> 10);
            f = int'(cq & 1023);
            if (idx >= 16) asn = 9000;
            else asn = ASIN_LUT[idx] + (((ASIN_LUT[idx+1] - ASIN_LUT[idx]) * f + 512) >> 10);
            angle = (dot < 0) ? 9000 + asn : 9000 - asn;
        end
        e = tanh_fix((ng + 2560) / 5120);
        sa = inv_tanh(tanh_fix((longint'(angle) * 1024 + 1500) / 3000));
        sg = inv_tanh(tanh_fix((longint'(max_gray) * 4 + 12) / 25));
        return int'((((e * sa) >> 16) * sg) >> 16);
    endfunction

    task automatic predict_column();
        bit        side;
        bit [11:0] x;
        bit [11:0] y;
        bit [15:0] cur[3];
        bit [15:0] lft[3];
        bit [15:0] rgt[3];
        int unsigned s;
        edge_point_t p;
        side = s_tuser[0];
        x = s_tdata[11:0];
        y = s_tdata[23:12];
        if (s_tuser[1]) begin
            cols_held = 0;
            max_gray = 0;
            top_score = 0;
            best_col = 0;
        end
        cur[0] = luma(s_tdata[47:24]);
        cur[1] = luma(s_tdata[71:48]);
        cur[2] = luma(s_tdata[95:72]);
        if (cols_held >= 2) begin
            if (side) begin
                lft = cur;
                rgt = gray_old;
            end else begin
                lft = gray_old;
                rgt = cur;
            end
            if (gray_new[1] > max_gray) max_gray = gray_new[1];
            s = col_score(lft, gray_new, rgt, ctr_col, y);
            if (s > top_score) begin
                top_score = 16'(s);
                best_col = ctr_col;
            end
        end
        gray_old = gray_new;
        gray_new = cur;
        ctr_col = x;
        if (cols_held < 2) cols_held++;
        if (s_tlast) begin
            p.found = top_score >= min_conf;
            if (side == 1'b0) begin
                if (best_col <= border) p.found = 0;
            end else begin
                if (32'(best_col) + 1 + border >= frm_w) p.found = 0;
            end
            p.side = side;
            p.px = p.found ? best_col : 12'd0;
            p.row = y;
            p.score = p.found ? top_score : 16'd0;
            points_due.push_back(p);
        end
    endtask

    task automatic compare_point();
        edge_point_t p;
        if (points_due.size() == 0) begin
            $error("result transfer with no result expected");
            errs++;
            return;
        end
        p = points_due.pop_front();
        if (m_tuser[0] !== p.side) begin
            $error("side_out expected %0d actual %0d", p.side, m_tuser[0]);
            errs++;
        end
        if (m_tuser[1] !== p.found) begin
            $error("point_valid expected %0d actual %0d", p.found, m_tuser[1]);
            errs++;
        end
        if (m_tdata[11:0] !== p.px) begin
            $error("point_x expected %0d actual %0d", p.px, m_tdata[11:0]);
            errs++;
        end
        if (m_tdata[23:12] !== p.row) begin
            $error("row_out expected %0d actual %0d", p.row, m_tdata[23:12]);
            errs++;
        end
        if (m_tdata[39:24] !== p.score) begin
            $error("score expected %0d actual %0d", p.score, m_tdata[39:24]);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            frm_w = 13'd640;
            frm_h = 13'd480;
            min_conf = 16'd1966;
            border = 8'd3;
            gray_new = '{default: 0};
            gray_old = '{default: 0};
            cols_held = 0;
            ctr_col = 0;
            max_gray = 0;
            top_score = 0;
            best_col = 0;
            points_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH: frm_w = cfg_data[12:0];
                    CFG_FRAME_HEIGHT: frm_h = cfg_data[12:0];
                    CFG_MIN_CONFIDENCE: min_conf = cfg_data;
                    CFG_BORDER_DISCARD: border = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_column();
            if (m_tvalid && m_tready) compare_point();
        end
        fail_count <= errs;
        awaited <= points_due.size();
    end

endmodule

// File: bench/testbench.sv
// Top of the radial edge point finder bench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps
module testbench import repf_pkg::*;;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [15:0]           cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    int                    fail_count;
    int                    awaited;

    int  src_idle = 11;
    int  snk_idle = 63;
    bit  hold_req = 0;
    bit  hold_seen = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  cols_sent = 0;
    bit [12:0] cur_w = 13'd640;
    bit [12:0] cur_h = 13'd480;

    radial_edge_point_finder_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    edge_point_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .awaited(awaited)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= 3000;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic put_col(input bit side, input bit st, input bit en, input bit [11:0] x,
                           input bit [11:0] y, input bit [23:0] t, input bit [23:0] m,
                           input bit [23:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, m, t, y, x};
        s_tuser <= {st, side};
        s_tlast <= en;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cols_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_regs(input bit [12:0] w, input bit [12:0] h, input bit [15:0] mc,
                              input bit [7:0] bd);
        bit [15:0] vals[4];
        logic [1:0] idx[4];
        vals = '{16'(w), 16'(h), mc, 16'(bd)};
        idx = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_MIN_CONFIDENCE, CFG_BORDER_DISCARD};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    function automatic bit [23:0] shade(input int lvl);
        bit [7:0] c[3];
        for (int i = 0; i < 3; i++) begin
            c[i] = 8'((lvl + $urandom_range(0, 3)) > 255 ? 255 : lvl + $urandom_range(0, 3));
        end
        if ($urandom_range(7) == 0) return 24'($urandom);
        return {c[2], c[1], c[0]};
    endfunction

    task automatic random_scan();
        bit side;
        int natural_len;
        int len;
        int bg;
        int fg;
        int step_at;
        int lvl;
        int tilt;
        bit [11:0] x;
        bit [11:0] y;
        if ($urandom_range(99) < 15) begin
            put_col(1'($urandom_range(1)), $urandom_range(3) == 0, $urandom_range(3) == 0,
                    12'($urandom), 12'($urandom_range(1, 4094)), 24'($urandom),
                    24'($urandom), 24'($urandom));
            return;
        end
        side = 1'($urandom_range(1));
        natural_len = side ? (cur_w - cur_w / 2) : (cur_w / 2 + 1);
        len = $urandom_range(1, 40);
        if (len > natural_len) len = natural_len;
        y = 12'((cur_h >= 3) ? $urandom_range(1, cur_h - 2) : 1);
        if (y > 4094) y = 4094;
        bg = $urandom_range(0, 12);
        fg = $urandom_range(0, 60);
        step_at = $urandom_range(0, len);
        tilt = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            x = side ? 12'(cur_w - 1 - i) : 12'(i);
            lvl = (i < step_at) ? bg : fg;
            put_col(side, i == 0 && $urandom_range(19) != 0, i == len - 1, x, y,
                    shade(lvl), shade(lvl + tilt), shade(lvl + 2 * tilt));
        end
    endtask

    task automatic directed_part();
        put_col(0, 1, 1, 0, 240, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        for (int i = 0; i < 6; i++)
            put_col(0, i == 0, i == 5, 12'(i), 240, i < 3 ? 0 : 24'h141414,
                    i < 3 ? 0 : 24'h141414, i < 3 ? 0 : 24'h141414);
        for (int i = 0; i < 5; i++)
            put_col(1, i == 0, i == 4, 12'(639 - i), 100, i < 2 ? 24'h0A0A0A : 0,
                    i < 2 ? 24'h0A0A0A : 0, 24'h050505);
        put_col(1, 0, 0, 12'hFFF, 4094, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        put_col(0, 0, 1, 0, 1, 0, 0, 0);
        put_col(0, 1, 0, 0, 300, 24'h101010, 24'h101010, 24'h101010);
        put_col(1, 0, 0, 1, 300, 24'h101010, 24'h101010, 24'h101010);
        put_col(0, 0, 1, 2, 301, 24'h101010, 24'h101010, 24'h101010);
        drain();
        write_regs(8, 8, 0, 0);
        for (int i = 0; i < 6; i++)
            put_col(0, i == 0, i == 5, 12'(i), 4, 24'(i * 24'h030303),
                    24'(i * 24'h020202), 24'(i * 24'h010101));
        drain();
    endtask

    initial begin
        bit [12:0] pw[4];
        bit [12:0] ph[4];
        bit [15:0] pm[4];
        bit [7:0]  pb[4];
        int        target;
        pw = '{13'd64, 13'd4096, 13'd40, 13'd3};
        ph = '{13'd4096, 13'd3, 13'd30, 13'd4096};
        pm = '{16'd0, 16'd65535, 16'd500, 16'd1966};
        pb = '{8'd0, 8'd255, 8'd2, 8'd1};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_part();
        for (int p = 0; p < 4; p++) begin
            drain();
            write_regs(pw[p], ph[p], pm[p], pb[p]);
            src_idle = (p == 0) ? 11 : (p == 1) ? 63 : 0;
            snk_idle = (p == 0) ? 63 : (p == 1) ? 11 : 0;
            target = cols_sent + 190;
            while (cols_sent < target) begin
                random_scan();
                if (p == 2 && cols_sent > target - 150) hold_req <= 1'b1;
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: radial_edge_point_finder_core.f
rtl/repf_pkg.sv
rtl/repf_front.sv
rtl/repf_queue.sv
rtl/repf_isqrt.sv
rtl/repf_back.sv
rtl/radial_edge_point_finder_core.sv
bench/edge_point_checker.sv
bench/testbench.sv
